### rtl/gsv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GTIN string validator package
// Field widths, character codes, status codes and the structs passed between
// the validator modules.
// ----------------------------------------------------------------------------
package gsv_pkg;

    localparam int CHAR_W   = 8;
    localparam int COUNT_W  = 5;
    localparam int SUM_W    = 4;
    localparam int VALUE_W  = 60;
    localparam int STATUS_W = 3;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_DASH  = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

    typedef enum logic [STATUS_W-1:0] {
        ST_VALID   = 3'd0,
        ST_EMPTY   = 3'd1,
        ST_INVALID = 3'd2,
        ST_LONG    = 3'd3,
        ST_CHECK   = 3'd4
    } t_status;

    // One byte item handed from the input register to the accumulator.
    typedef struct packed {
        logic              take;
        logic [CHAR_W-1:0] char_code;
        logic              end_of_string;
    } t_item;

    typedef struct packed {
        t_status            status;
        logic [COUNT_W-1:0] digit_count;
        logic [VALUE_W-1:0] gtin_value;
    } t_result;

endpackage

### rtl/gsv_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GTIN string validator channels
// Valid/ready channels for the character items and for the result items.
// ----------------------------------------------------------------------------
interface gsv_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_string;

    modport source (output valid, output char_code, output end_of_string, input ready);
    modport sink   (input valid, input char_code, input end_of_string, output ready);
endinterface

interface gsv_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [4:0]  digit_count;
    logic [59:0] gtin_value;

    modport source (output valid, output status, output digit_count, output gtin_value,
                    input ready);
    modport sink   (input valid, input status, input digit_count, input gtin_value,
                    output ready);
endinterface

### rtl/gsv_accum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GTIN string accumulator
// Holds the running state of the current string and forms its result.
// ----------------------------------------------------------------------------
module gsv_accum #(
    parameter int unsigned MAX_DIGITS = 18
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  gsv_pkg::t_item   i_item,
    output gsv_pkg::t_result o_result
);
    import gsv_pkg::*;

    localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_DIGITS);
    localparam logic [COUNT_W-1:0] SAT_CNT = COUNT_W'(MAX_DIGITS + 1);

    logic               r_any, n_any;
    logic               r_lead, n_lead;
    logic               r_bad, n_bad;
    logic [COUNT_W-1:0] r_kept, n_kept;
    logic [SUM_W-1:0]   r_even, n_even;
    logic [SUM_W-1:0]   r_odd, n_odd;
    logic [VALUE_W-1:0] r_value, n_value;

    logic [CHAR_W-1:0]  w_diff;
    logic [SUM_W-1:0]   w_digit;
    logic               w_is_digit;
    logic               w_is_sep;
    logic [SUM_W:0]     w_sum_in;
    logic [SUM_W:0]     w_sum_raw;
    logic [SUM_W-1:0]   w_sum_mod;
    logic [VALUE_W-1:0] w_value_next;
    logic [SUM_W-1:0]   w_w1;
    logic [SUM_W-1:0]   w_w3;
    logic [5:0]         w_total;
    logic               w_check_ok;

    assign w_diff     = i_item.char_code - CHAR_ZERO;
    assign w_digit    = w_diff[SUM_W-1:0];
    assign w_is_digit = i_item.char_code inside {[CHAR_ZERO:CHAR_NINE]};
    assign w_is_sep   = i_item.char_code inside {CHAR_SPACE, CHAR_DASH};

    // Digits alternate between the two parity sums by their index from the left.
    assign w_sum_in  = r_kept[0] ? {1'b0, r_odd} : {1'b0, r_even};
    assign w_sum_raw = w_sum_in + {1'b0, w_digit};
    assign w_sum_mod = (w_sum_raw >= 5'd10) ? SUM_W'(w_sum_raw - 5'd10)
                                           : w_sum_raw[SUM_W-1:0];

    assign w_value_next = {r_value[VALUE_W-4:0], 3'b000} + {r_value[VALUE_W-2:0], 1'b0}
                        + {{(VALUE_W-SUM_W){1'b0}}, w_digit};

    always_comb begin
        n_any   = r_any;
        n_lead  = r_lead;
        n_bad   = r_bad;
        n_kept  = r_kept;
        n_even  = r_even;
        n_odd   = r_odd;
        n_value = r_value;
        if (i_item.take) begin
            if (i_item.end_of_string) begin
                n_any   = 1'b0;
                n_lead  = 1'b1;
                n_bad   = 1'b0;
                n_kept  = '0;
                n_even  = '0;
                n_odd   = '0;
                n_value = '0;
            end else begin
                n_any = 1'b1;
                if (!(r_lead && i_item.char_code == CHAR_ZERO)) begin
                    n_lead = 1'b0;
                    if (w_is_digit) begin
                        if (r_kept < MAX_CNT) begin
                            if (r_kept[0]) begin
                                n_odd = w_sum_mod;
                            end else begin
                                n_even = w_sum_mod;
                            end
                            n_value = w_value_next;
                            n_kept  = r_kept + 1'b1;
                        end else begin
                            n_kept = SAT_CNT;
                        end
                    end else if (!w_is_sep) begin
                        n_bad = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_any   <= 1'b0;
            r_lead  <= 1'b1;
            r_bad   <= 1'b0;
            r_kept  <= '0;
            r_even  <= '0;
            r_odd   <= '0;
            r_value <= '0;
        end else begin
            r_any   <= n_any;
            r_lead  <= n_lead;
            r_bad   <= n_bad;
            r_kept  <= n_kept;
            r_even  <= n_even;
            r_odd   <= n_odd;
            r_value <= n_value;
        end
    end

    // The rightmost digit has weight 1, so the weights follow the count's parity.
    assign w_w1    = r_kept[0] ? r_even : r_odd;
    assign w_w3    = r_kept[0] ? r_odd : r_even;
    assign w_total = {2'b00, w_w1} + {2'b00, w_w3} + {1'b0, w_w3, 1'b0};
    assign w_check_ok = w_total inside {6'd0, 6'd10, 6'd20, 6'd30};

    always_comb begin
        o_result.digit_count = r_kept;
        o_result.gtin_value  = '0;
        if (!r_any) begin
            o_result.status = ST_EMPTY;
        end else if (r_bad || r_kept == '0) begin
            o_result.status = ST_INVALID;
        end else if (r_kept > MAX_CNT) begin
            o_result.status = ST_LONG;
        end else if (!w_check_ok) begin
            o_result.status = ST_CHECK;
        end else begin
            o_result.status     = ST_VALID;
            o_result.gtin_value = r_value;
        end
    end

endmodule

### rtl/gsv_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GTIN result register
// Holds one finished result item until the downstream side takes it.
// ----------------------------------------------------------------------------
module gsv_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  gsv_pkg::t_result i_result,
    output logic             o_free,
    gsv_result_if.source     o_result
);
    import gsv_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_free = !r_valid || o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_result.valid       = r_valid;
    assign o_result.status      = r_result.status;
    assign o_result.digit_count = r_result.digit_count;
    assign o_result.gtin_value  = r_result.gtin_value;

endmodule

### rtl/gtin_string_validator.sv
`timescale 1ns / 1ps
// The result of an end item is valid from the edge at which that item leaves the input
// register, which it can leave only when the result register is free.
// Throughput: one item per cycle; only an end item waits, for the result register.
// Reset: synchronous, active low; clears the handshake state and the string state.
// ----------------------------------------------------------------------------
// GTIN string validator
// Checks a byte stream as a GS1 GTIN with the mod-10 check digit.
// ----------------------------------------------------------------------------
module gtin_string_validator #(
    parameter int unsigned MAX_DIGITS = 18
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    gsv_char_if.sink     i_char,
    gsv_result_if.source o_result
);
    import gsv_pkg::*;

    logic              r_in_valid;
    logic [CHAR_W-1:0] r_in_char;
    logic              r_in_eos;
    logic              w_out_free;
    logic              w_take;
    t_item             w_item;
    t_result           w_result;

    // An ordinary byte always moves on; an end item needs the result register.
    assign w_take       = r_in_valid && (!r_in_eos || w_out_free);
    assign i_char.ready = !r_in_valid || w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_char.ready) begin
            r_in_valid <= i_char.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_char.valid && i_char.ready) begin
            r_in_char <= i_char.char_code;
            r_in_eos  <= i_char.end_of_string;
        end
    end

    assign w_item.take          = w_take;
    assign w_item.char_code     = r_in_char;
    assign w_item.end_of_string = r_in_eos;

    gsv_accum #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_accum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (w_item),
        .o_result (w_result)
    );

    gsv_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_take && r_in_eos),
        .i_result (w_result),
        .o_free   (w_out_free),
        .o_result (o_result)
    );

endmodule

### rtl/gsv_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GTIN string validator checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module gsv_checker #(
    parameter int unsigned MAX_DIGITS = 18
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  i_status,
    input logic [4:0]  i_digit_count,
    input logic [59:0] i_gtin_value
);
    import gsv_pkg::*;

    localparam logic [COUNT_W-1:0] SAT_CNT = COUNT_W'(MAX_DIGITS + 1);

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status)
            && $stable(i_digit_count) && $stable(i_gtin_value))
        else $error("result item changed while stalled");

    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status != ST_VALID |-> i_gtin_value == '0)
        else $error("non-zero value on a failed string");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == ST_EMPTY |-> i_digit_count == '0)
        else $error("empty string reports digits");

    a_long_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == ST_LONG |-> i_digit_count == SAT_CNT)
        else $error("too-long string without saturated count");

endmodule

bind gtin_string_validator gsv_checker #(
    .MAX_DIGITS (MAX_DIGITS)
) u_gsv_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_result.valid),
    .i_out_ready   (o_result.ready),
    .i_status      (o_result.status),
    .i_digit_count (o_result.digit_count),
    .i_gtin_value  (o_result.gtin_value)
);

### verif/gsv_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GTIN string validator checker
// Watches the character and result channels, predicts the result of every
// string from the accepted bytes and compares each result field by field.
// ----------------------------------------------------------------------------
module gsv_tb_checker #(
    parameter int unsigned MAX_DIGITS = 18
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    gsv_char_if   i_char,
    gsv_result_if i_result,
    output int    o_fail_count,
    output int    o_pending,
    output int    o_results_seen
);
    import gsv_pkg::*;

    // Only the first mismatches are printed so a broken design cannot flood the log.
    localparam int MAX_PRINTED = 30;

    logic               string_seen;
    logic               zero_run;
    logic               bad_byte;
    logic [COUNT_W-1:0] digit_total;
    logic [SUM_W-1:0]   even_sum;
    logic [SUM_W-1:0]   odd_sum;
    logic [VALUE_W-1:0] value_sum;
    t_result            expected_results[$];

    initial begin
        o_fail_count   = 0;
        o_pending      = 0;
        o_results_seen = 0;
    end

    task automatic report_mismatch(input string msg);
        if (o_fail_count < MAX_PRINTED) begin
            $display("%0t ns MISMATCH: %s", $time, msg);
        end
        o_fail_count++;
    endtask

    function automatic void clear_string();
        string_seen = 1'b0;
        zero_run    = 1'b1;
        bad_byte    = 1'b0;
        digit_total = '0;
        even_sum    = '0;
        odd_sum     = '0;
        value_sum   = '0;
    endfunction

    function automatic void absorb_byte(input logic [CHAR_W-1:0] code);
        logic [3:0] digit;
        digit       = 4'(code - CHAR_ZERO);
        string_seen = 1'b1;
        if (zero_run && code == CHAR_ZERO) begin
            return;
        end
        zero_run = 1'b0;
        if (code >= CHAR_ZERO && code <= CHAR_NINE) begin
            if (digit_total < MAX_DIGITS) begin
                // Digits are summed by their position counted from the left.
                if (!digit_total[0]) begin
                    even_sum = SUM_W'((even_sum + digit) % 10);
                end else begin
                    odd_sum = SUM_W'((odd_sum + digit) % 10);
                end
                value_sum   = value_sum * 10 + digit;
                digit_total = digit_total + 1'b1;
            end else begin
                digit_total = COUNT_W'(MAX_DIGITS + 1);
            end
        end else if (code != CHAR_SPACE && code != CHAR_DASH) begin
            bad_byte = 1'b1;
        end
    endfunction

    function automatic t_result close_string();
        t_result res;
        int      weighted;
        // The rightmost digit always carries weight one.
        if (digit_total[0]) begin
            weighted = even_sum + 3 * odd_sum;
        end else begin
            weighted = odd_sum + 3 * even_sum;
        end
        res.digit_count = digit_total;
        res.gtin_value  = '0;
        if (!string_seen) begin
            res.status = ST_EMPTY;
        end else if (bad_byte || digit_total == 0) begin
            res.status = ST_INVALID;
        end else if (digit_total > MAX_DIGITS) begin
            res.status = ST_LONG;
        end else if (weighted % 10 != 0) begin
            res.status = ST_CHECK;
        end else begin
            res.status     = ST_VALID;
            res.gtin_value = value_sum;
        end
        clear_string();
        return res;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_result exp_res;
        if (!i_rst_n) begin
            clear_string();
            expected_results.delete();
        end else begin
            if (i_result.valid && i_result.ready) begin
                o_results_seen++;
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf(
                        "result with no string pending: status %0d count %0d value %0d",
                        i_result.status, i_result.digit_count, i_result.gtin_value));
                end else begin
                    exp_res = expected_results.pop_front();
                    if (i_result.status !== exp_res.status) begin
                        report_mismatch($sformatf("status %0d, expected %0d",
                            i_result.status, exp_res.status));
                    end
                    if (i_result.digit_count !== exp_res.digit_count) begin
                        report_mismatch($sformatf("digit_count %0d, expected %0d",
                            i_result.digit_count, exp_res.digit_count));
                    end
                    if (i_result.gtin_value !== exp_res.gtin_value) begin
                        report_mismatch($sformatf("gtin_value %0d, expected %0d",
                            i_result.gtin_value, exp_res.gtin_value));
                    end
                end
            end
            if (i_char.valid && i_char.ready) begin
                if (i_char.end_of_string) begin
                    expected_results.push_back(close_string());
                end else begin
                    absorb_byte(i_char.char_code);
                end
            end
        end
        o_pending = expected_results.size();
    end

endmodule

### verif/gtin_string_validator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GTIN string validator testbench
// Sends directed and random byte strings in bursts while the result side
// stalls on its own pattern, including one long hold that backs up the input.
// A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module gtin_string_validator_tb;
    import gsv_pkg::*;

    localparam int unsigned MAX_DIGITS      = 18;
    localparam int          RANDOM_ITEMS    = 450;
    localparam int          MIN_STRINGS     = 40;
    localparam int          HOLD_OFF_CYCLES = 200;
    localparam int          HOLD_OFF_START  = 300;
    localparam int          DRAIN_CYCLES    = 8;
    localparam int          IDLE_LIMIT      = 2000;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              is_end;
    } t_stim_byte;

    logic       i_clk;
    logic       i_rst_n;
    t_stim_byte stim_bytes[$];
    int         strings_built = 0;
    int         fail_count;
    int         pending;
    int         results_seen;
    int         idle_cycles   = 0;

    gsv_char_if   char_ch ();
    gsv_result_if result_ch ();

    gtin_string_validator #(
        .MAX_DIGITS(MAX_DIGITS)
    ) u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_char   (char_ch),
        .o_result (result_ch)
    );

    gsv_tb_checker #(
        .MAX_DIGITS(MAX_DIGITS)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_char         (char_ch),
        .i_result       (result_ch),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_results_seen (results_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    task automatic push_byte(input logic [CHAR_W-1:0] code);
        stim_bytes.push_back('{code: code, is_end: 1'b0});
    endtask

    // The character field of an end item is ignored, so it carries noise.
    task automatic push_end(input logic [CHAR_W-1:0] code);
        stim_bytes.push_back('{code: code, is_end: 1'b1});
        strings_built++;
    endtask

    function automatic logic [CHAR_W-1:0] rand_bad_byte();
        logic [CHAR_W-1:0] code;
        do begin
            code = CHAR_W'($urandom_range(0, 255));
        end while ((code >= CHAR_ZERO && code <= CHAR_NINE) || code == CHAR_SPACE ||
                   code == CHAR_DASH);
        return code;
    endfunction

    // Builds one number string: leading zeros, digits whose last one is the
    // check digit (right or deliberately wrong), optional separators and an
    // optional forbidden byte at a random spot.
    task automatic add_number(input int n_sig, input int n_lead, input bit good_check,
                              input bit with_bad, input bit with_seps);
        int digits[$];
        int weighted;
        int check;
        int bad_at;
        weighted = 0;
        for (int i = 0; i < n_sig; i++) begin
            digits.push_back((i == 0) ? $urandom_range(1, 9) : $urandom_range(0, 9));
        end
        for (int i = 1; i < n_sig; i++) begin
            weighted += digits[n_sig - 1 - i] * ((i % 2) ? 3 : 1);
        end
        check = (10 - weighted % 10) % 10;
        if (!good_check) begin
            check = (check + $urandom_range(1, 9)) % 10;
        end
        digits[n_sig - 1] = check;
        bad_at = with_bad ? $urandom_range(0, n_sig) : -1;
        for (int i = 0; i < n_lead; i++) begin
            push_byte(CHAR_ZERO);
        end
        for (int i = 0; i < n_sig; i++) begin
            if (i == bad_at) begin
                push_byte(rand_bad_byte());
            end
            if (with_seps && $urandom_range(0, 4) == 0) begin
                push_byte($urandom_range(0, 1) ? CHAR_SPACE : CHAR_DASH);
            end
            push_byte(CHAR_ZERO + CHAR_W'(digits[i]));
        end
        if (bad_at == n_sig) begin
            push_byte(rand_bad_byte());
        end
        push_end(CHAR_W'($urandom_range(0, 255)));
    endtask

    task automatic send_all();
        int burst_left;
        burst_left = 0;
        for (int k = 0; k < stim_bytes.size(); k++) begin
            if (burst_left == 0) begin
                if ($urandom_range(0, 3) != 0) begin
                    char_ch.valid         <= 1'b0;
                    char_ch.char_code     <= CHAR_W'($urandom_range(0, 255));
                    char_ch.end_of_string <= 1'($urandom_range(0, 1));
                    repeat ($urandom_range(1, 8)) @(posedge i_clk);
                end
                burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                         : $urandom_range(1, 12);
            end
            char_ch.valid         <= 1'b1;
            char_ch.char_code     <= stim_bytes[k].code;
            char_ch.end_of_string <= stim_bytes[k].is_end;
            burst_left--;
            @(posedge i_clk);
            while (!char_ch.ready) @(posedge i_clk);
        end
        char_ch.valid <= 1'b0;
    endtask

    initial begin : stimulus
        int kind;
        int len;
        int count;
        int directed_items;
        i_rst_n               <= 1'b0;
        char_ch.valid         <= 1'b0;
        char_ch.char_code     <= '0;
        char_ch.end_of_string <= 1'b0;

        // Directed strings around the edges of the character classes.
        push_end(8'hFF);                                        // empty string
        push_byte(CHAR_ZERO); push_byte(CHAR_ZERO); push_end(8'h00);       // zeros only
        push_byte(CHAR_SPACE); push_byte(CHAR_DASH); push_end(8'h55);      // separators only
        push_byte(8'h00); push_end(8'hAA);                      // byte value zero
        push_byte(CHAR_DASH); push_byte(CHAR_ZERO); push_end(8'h00);       // zero kept
        push_byte(CHAR_ZERO); push_byte(CHAR_ZERO + 8'd4); push_end(8'h0F); // wrong check
        push_byte(CHAR_ZERO - 8'd1); push_byte(CHAR_ZERO + 8'd5); push_end(8'hF0);
        push_byte(CHAR_NINE + 8'd1); push_end(8'h33);
        push_byte(CHAR_ZERO + 8'd5); push_byte(CHAR_ZERO + 8'd5); push_end(8'hCC);
        push_byte(8'hFF); push_end(8'h7F);
        directed_items = stim_bytes.size();

        // Longest valid number, one digit too many, and a bad byte in a long one.
        add_number(MAX_DIGITS, 0, 1'b1, 1'b0, 1'b0);
        add_number(MAX_DIGITS + 1, 1, 1'b1, 1'b0, 1'b0);
        add_number(MAX_DIGITS + 2, 0, 1'b1, 1'b1, 1'b1);

        while (stim_bytes.size() < directed_items + RANDOM_ITEMS ||
               strings_built < MIN_STRINGS) begin
            kind = $urandom_range(0, 99);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: len = $urandom_range(1, 6);
                6, 7, 8: begin
                    case ($urandom_range(0, 3))
                        0:       len = 8;
                        1:       len = 12;
                        2:       len = 13;
                        default: len = 14;
                    endcase
                end
                default: len = $urandom_range(15, MAX_DIGITS);
            endcase
            if (kind < 50) begin
                add_number(len, $urandom_range(0, 3), 1'b1, 1'b0, 1'($urandom_range(0, 1)));
            end else if (kind < 65) begin
                add_number(len, $urandom_range(0, 3), 1'b0, 1'b0, 1'($urandom_range(0, 1)));
            end else if (kind < 75) begin
                add_number($urandom_range(MAX_DIGITS + 1, MAX_DIGITS + 6),
                           $urandom_range(0, 2), 1'($urandom_range(0, 1)), 1'b0,
                           1'($urandom_range(0, 1)));
            end else if (kind < 85) begin
                if ($urandom_range(0, 3) == 0) begin
                    len = $urandom_range(MAX_DIGITS + 1, MAX_DIGITS + 3);
                end
                add_number(len, $urandom_range(0, 2), 1'b1, 1'b1, 1'($urandom_range(0, 1)));
            end else if (kind < 90) begin
                push_end(CHAR_W'($urandom_range(0, 255)));
            end else if (kind < 95) begin
                count = $urandom_range(1, 5);
                for (int i = 0; i < count; i++) begin
                    case ($urandom_range(0, 2))
                        0:       push_byte(CHAR_ZERO);
                        1:       push_byte(CHAR_SPACE);
                        default: push_byte(CHAR_DASH);
                    endcase
                end
                push_end(CHAR_W'($urandom_range(0, 255)));
            end else begin
                count = $urandom_range(1, 6);
                for (int i = 0; i < count; i++) begin
                    push_byte(CHAR_W'($urandom_range(0, 255)));
                end
                push_end(CHAR_W'($urandom_range(0, 255)));
            end
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_all();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d strings in %0d byte items, %0d results compared.",
                 strings_built, stim_bytes.size(), results_seen);
        $display("Strings included empty, zero-only, separator, bad-byte, overlong and ",
                 "wrong-check cases, under bursty input and a long output hold.");
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Result side: segments of free flow, light stalls and heavy stalls, plus
    // one long hold so that the block backs up into the input channel.
    initial begin : receiver
        int seg_len;
        int mode;
        int cycle_no;
        bit hold_done;
        cycle_no  = 0;
        hold_done = 1'b0;
        forever begin
            if (!hold_done && cycle_no >= HOLD_OFF_START) begin
                hold_done = 1'b1;
                result_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end
            seg_len = $urandom_range(10, 60);
            mode    = $urandom_range(0, 2);
            repeat (seg_len) begin
                case (mode)
                    0:       result_ch.ready <= 1'b1;
                    1:       result_ch.ready <= 1'($urandom_range(0, 1));
                    default: result_ch.ready <= ($urandom_range(0, 4) == 0);
                endcase
                @(posedge i_clk);
                cycle_no++;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((char_ch.valid && char_ch.ready) || (result_ch.valid && result_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no item moved for %0d cycles", IDLE_LIMIT);
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
